FILE: src/srhp_pkg.sv
// shared types, constants and the name-match table for the replaces header parser
// no dependencies; imported by every module of the block
package srhp_pkg;

  localparam int MAX_LEN = 1024;
  localparam int POS_W   = 11;
  localparam int Q_DEPTH = 2;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t MAX_POS = pos_t'(MAX_LEN);

  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_EQ   = 8'h3d;
  localparam logic [7:0] CH_DASH = 8'h2d;
  localparam logic [7:0] CH_UC_A = 8'h41;
  localparam logic [7:0] CH_UC_Z = 8'h5a;
  localparam logic [7:0] CH_CASE = 8'h20;

  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_E = 8'h65;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_G = 8'h67;
  localparam logic [7:0] CH_L = 8'h6c;
  localparam logic [7:0] CH_M = 8'h6d;
  localparam logic [7:0] CH_N = 8'h6e;
  localparam logic [7:0] CH_O = 8'h6f;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_Y = 8'h79;
  localparam logic [7:0] CH_NONE = 8'h00;

  typedef enum logic [4:0] {
    ST_CALLID    = 5'd0,
    ST_PARAM     = 5'd1,
    ST_SKIP      = 5'd2,
    ST_SKIPVAL   = 5'd3,
    ST_VALUE     = 5'd4,
    ST_T1        = 5'd5,
    ST_T2        = 5'd6,
    ST_T3        = 5'd7,
    ST_T4        = 5'd8,
    ST_T5        = 5'd9,
    ST_T6        = 5'd10,
    ST_TO_EQ     = 5'd11,
    ST_F1        = 5'd12,
    ST_F2        = 5'd13,
    ST_F3        = 5'd14,
    ST_F4        = 5'd15,
    ST_F5        = 5'd16,
    ST_F6        = 5'd17,
    ST_F7        = 5'd18,
    ST_F8        = 5'd19,
    ST_FROM_EQ   = 5'd20,
    ST_E1        = 5'd21,
    ST_E2        = 5'd22,
    ST_E3        = 5'd23,
    ST_E4        = 5'd24,
    ST_E5        = 5'd25,
    ST_E6        = 5'd26,
    ST_E7        = 5'd27,
    ST_E8        = 5'd28,
    ST_E9        = 5'd29,
    ST_EARLY_FIN = 5'd30,
    ST_EARLY_EQ  = 5'd31
  } state_t;

  typedef enum logic [1:0] {
    TGT_NONE  = 2'd0,
    TGT_TO    = 2'd1,
    TGT_FROM  = 2'd2,
    TGT_EARLY = 2'd3
  } tgt_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       last;
  } srhp_in_t;

  typedef struct packed {
    pos_t callid_len;
    pos_t to_tag_start;
    pos_t to_tag_len;
    pos_t from_tag_start;
    pos_t from_tag_len;
    pos_t early_start;
    pos_t early_len;
    pos_t early_value_start;
    pos_t early_value_len;
    logic too_long;
  } srhp_out_t;

  // classified byte as it travels from front to back
  typedef struct packed {
    logic [7:0] lc;
    logic       semi;
    logic       eq;
    logic       last;
  } srhp_tok_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
    logic               full;
    logic               empty;
  } srhp_qstat_t;

  // character that advances a name-matching state
  function automatic logic [7:0] name_next(input state_t s);
    logic [7:0] ch;
    case (s)
      ST_T1:   ch = CH_O;
      ST_T2:   ch = CH_DASH;
      ST_T3:   ch = CH_T;
      ST_T4:   ch = CH_A;
      ST_T5:   ch = CH_G;
      ST_T6:   ch = CH_EQ;
      ST_F1:   ch = CH_R;
      ST_F2:   ch = CH_O;
      ST_F3:   ch = CH_M;
      ST_F4:   ch = CH_DASH;
      ST_F5:   ch = CH_T;
      ST_F6:   ch = CH_A;
      ST_F7:   ch = CH_G;
      ST_F8:   ch = CH_EQ;
      ST_E1:   ch = CH_A;
      ST_E2:   ch = CH_R;
      ST_E3:   ch = CH_L;
      ST_E4:   ch = CH_Y;
      ST_E5:   ch = CH_DASH;
      ST_E6:   ch = CH_O;
      ST_E7:   ch = CH_N;
      ST_E8:   ch = CH_L;
      ST_E9:   ch = CH_Y;
      default: ch = CH_NONE;
    endcase
    return ch;
  endfunction

endpackage

FILE: src/srhp_front.sv
// front end: folds case and flags the delimiter bytes of each accepted item
// depends on srhp_pkg
module srhp_front import srhp_pkg::*; (
  input  srhp_in_t  in_item,
  output srhp_tok_t tok
);

  logic is_upper;

  assign is_upper = (in_item.body_byte >= CH_UC_A) && (in_item.body_byte <= CH_UC_Z);

  always_comb begin
    tok.lc   = is_upper ? (in_item.body_byte | CH_CASE) : in_item.body_byte;
    tok.semi = (in_item.body_byte == CH_SEMI);
    tok.eq   = (in_item.body_byte == CH_EQ);
    tok.last = in_item.last;
  end

endmodule

FILE: src/srhp_queue.sv
// short fifo of classified bytes between front and back
// depends on srhp_pkg
module srhp_queue import srhp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  srhp_tok_t   push_tok,
  input  logic        pop,
  output srhp_tok_t   head,
  output srhp_qstat_t stat
);

  srhp_tok_t          slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign head       = slots[rd_ptr];
  assign stat.count = count;
  assign stat.full  = (count == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/srhp_back.sv
// back end: parser state machine, offset bookkeeping and the result register
// depends on srhp_pkg
module srhp_back import srhp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      tok_valid,
  input  srhp_tok_t tok,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output srhp_out_t out_item
);

  state_t    state, state_next;
  pos_t      position, position_next;
  pos_t      param_begin, param_begin_next;
  pos_t      value_begin, value_begin_next;
  tgt_t      target, target_next;
  srhp_out_t found, found_next;
  pos_t      pos_cur;
  logic      sat;
  logic      callid_hit, value_hit, early_hit;
  pos_t      store_pos;
  logic      slot_free;

  assign slot_free = !out_valid || out_ready;
  assign pop       = tok_valid && (!tok.last || slot_free);

  always_comb begin
    sat           = (position >= MAX_POS);
    pos_cur       = sat ? MAX_POS : position;
    position_next = sat ? MAX_POS : position + 1'b1;

    state_next       = state;
    param_begin_next = param_begin;
    value_begin_next = value_begin;
    target_next      = target;
    found_next       = found;
    found_next.too_long = found.too_long | sat;

    case (state)
      ST_CALLID: begin
        if (tok.semi) state_next = ST_PARAM;
      end
      ST_PARAM: begin
        if (!tok.semi) begin
          param_begin_next = pos_cur;
          if (tok.lc == CH_T)      state_next = ST_T1;
          else if (tok.lc == CH_F) state_next = ST_F1;
          else if (tok.lc == CH_E) state_next = ST_E1;
        end
      end
      ST_SKIP: begin
        if (tok.semi)     state_next = ST_PARAM;
        else if (tok.eq)  state_next = ST_SKIPVAL;
      end
      ST_SKIPVAL: begin
        if (tok.semi) state_next = ST_PARAM;
      end
      ST_VALUE: begin
        if (tok.semi) state_next = ST_PARAM;
      end
      ST_TO_EQ, ST_FROM_EQ, ST_EARLY_EQ: begin
        target_next = (state == ST_TO_EQ) ? TGT_TO :
                      (state == ST_FROM_EQ) ? TGT_FROM : TGT_EARLY;
        if (tok.semi) begin
          state_next = ST_PARAM;
        end else begin
          value_begin_next = pos_cur;
          state_next       = ST_VALUE;
        end
      end
      ST_EARLY_FIN: begin
        if (tok.eq)        state_next = ST_EARLY_EQ;
        else if (tok.semi) state_next = ST_PARAM;
        else               state_next = ST_SKIP;
      end
      default: begin
        // name-matching states
        if (tok.lc == name_next(state)) state_next = state_t'(5'(state) + 5'd1);
        else if (tok.semi)              state_next = ST_PARAM;
        else                            state_next = ST_SKIP;
      end
    endcase

    // at most one store of each kind per byte: either at a semicolon or at the end
    callid_hit = (state == ST_CALLID && tok.semi) ||
                 (tok.last && state_next == ST_CALLID);
    value_hit  = (state == ST_VALUE && tok.semi) ||
                 (tok.last && state_next == ST_VALUE);
    early_hit  = (state == ST_EARLY_FIN && tok.semi) ||
                 (tok.last && (state_next == ST_EARLY_FIN || state_next == ST_EARLY_EQ));
    store_pos  = tok.semi ? pos_cur : position_next;

    if (callid_hit) found_next.callid_len = store_pos;
    if (early_hit) begin
      found_next.early_start = param_begin_next;
      found_next.early_len   = store_pos - param_begin_next;
    end
    if (value_hit) begin
      case (target_next)
        TGT_TO: begin
          found_next.to_tag_start = value_begin_next;
          found_next.to_tag_len   = store_pos - value_begin_next;
        end
        TGT_FROM: begin
          found_next.from_tag_start = value_begin_next;
          found_next.from_tag_len   = store_pos - value_begin_next;
        end
        TGT_EARLY: begin
          found_next.early_start       = param_begin_next;
          found_next.early_len         = store_pos - param_begin_next;
          found_next.early_value_start = value_begin_next;
          found_next.early_value_len   = store_pos - value_begin_next;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CALLID;
      position    <= '0;
      param_begin <= '0;
      value_begin <= '0;
      target      <= TGT_NONE;
      found       <= '0;
    end else if (pop) begin
      if (tok.last) begin
        state       <= ST_CALLID;
        position    <= '0;
        param_begin <= '0;
        value_begin <= '0;
        target      <= TGT_NONE;
        found       <= '0;
      end else begin
        state       <= state_next;
        position    <= position_next;
        param_begin <= param_begin_next;
        value_begin <= value_begin_next;
        target      <= target_next;
        found       <= found_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && tok.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && tok.last) begin
      out_item <= found_next;
    end
  end

endmodule

FILE: src/sip_replaces_header_parser_core.sv
// top level of the replaces header body parser
// depends on srhp_pkg, srhp_front, srhp_queue and srhp_back
//
// The parser takes one body byte per item and returns one result item after
// the byte marked last: the call-id length (call-id runs from offset 0 to the
// first semicolon) and the offsets and lengths of the to-tag, from-tag and
// early-only parameters, plus a too_long flag. Parameter names match without
// regard to case; dash and equals must match exactly. A later occurrence of a
// parameter overwrites an earlier one. Offsets saturate at MAX_LEN and set
// too_long. Throughput is one byte per clock: the front end folds case and
// tags delimiters, a two-entry queue decouples it from the back end, and the
// back end's state machine and offset registers retire one byte each cycle
// unless a last byte finds an earlier result still waiting. An accepted last
// byte passes through the queue slot to the back end, whose pop of it sets
// out_valid and loads the result register. The result register frees the back end
// as soon as it is taken, so a new body may begin right behind a pending
// result; only a second last byte waits for the result register to drain.
module sip_replaces_header_parser_core import srhp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  srhp_in_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output srhp_out_t out_item
);

  srhp_tok_t   front_tok;
  srhp_tok_t   head_tok;
  srhp_qstat_t q_stat;
  logic        push;
  logic        pop;

  // front accepts whenever the queue has room
  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  srhp_front u_front (
    .in_item (in_item),
    .tok     (front_tok)
  );

  srhp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_tok (front_tok),
    .pop      (pop),
    .head     (head_tok),
    .stat     (q_stat)
  );

  // back end pops one classified byte per cycle unless a last byte
  // finds the result register still occupied
  srhp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (!q_stat.empty),
    .tok       (head_tok),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // queue never overflows and stalls input only when full
  assert property (@(posedge clk) disable iff (rst)
    (q_stat.count <= Q_CNT_W'(Q_DEPTH)) && (in_ready || q_stat.full))
    else $error("queue occupancy out of range");

  // nothing pops from an empty queue
  assert property (@(posedge clk) disable iff (rst) pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // reported call-id, to-tag and early-only positions stay within the saturation bound
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.callid_len <= MAX_POS) &&
                  (out_item.to_tag_start + out_item.to_tag_len <= MAX_POS) &&
                  (out_item.early_start + out_item.early_len <= MAX_POS))
    else $error("result position beyond saturation bound");

endmodule

FILE: verif/tb.sv
// self-checking bench for sip_replaces_header_parser_core: header bodies go in one byte per item
// result items are checked against a parser model kept in the bench; needs srhp_pkg and the rtl
module tb import srhp_pkg::*; ();

  localparam int LIMIT_CYCLES = 300000;
  localparam int BODY_BYTES   = 1850;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 10;
  localparam int QUEUE_AHEAD  = 24;
  localparam int ERR_PRINTS   = 20;

  // kinds of parameter the body generator can emit
  typedef enum int {
    K_TO, K_FROM, K_EARLY, K_EARLY_VAL, K_UNKNOWN, K_BROKEN, K_JUNK, K_NOISE, K_EMPTY
  } param_kind_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  srhp_in_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  srhp_out_t out_item;

  string to_name    = "to-tag=";
  string from_name  = "from-tag=";
  string early_name = "early-only";

  // pending body bytes and expected result items
  srhp_in_t   body_bytes_q[$];
  srhp_out_t  span_q[$];
  logic [7:0] body_buf[$];

  // parser state mirrored in the bench
  state_t    ps_state;
  pos_t      ps_pos;
  pos_t      ps_param_at;
  pos_t      ps_value_at;
  tgt_t      ps_target;
  srhp_out_t ps_found;

  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  bit in_fired = 1'b0;
  int send_gap = 0;
  int hold_left = 0;
  int cycles = 0;
  int errors = 0;
  int results_checked = 0;
  int bytes_queued = 0;
  int bytes_sent = 0;
  int bodies_queued = 0;
  int long_bodies = 0;
  int in_stalls = 0;

  sip_replaces_header_parser_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- parser model

  // expected character for each name-matching state
  function automatic logic [7:0] name_char(state_t s);
    int idx;
    idx = int'(s);
    if (s >= ST_T1 && s <= ST_T6) return to_name[idx - int'(ST_T1) + 1];
    if (s >= ST_F1 && s <= ST_F8) return from_name[idx - int'(ST_F1) + 1];
    if (s >= ST_E1 && s <= ST_E9) return early_name[idx - int'(ST_E1) + 1];
    return CH_NONE;
  endfunction

  task automatic parse_reset();
    ps_state    = ST_CALLID;
    ps_pos      = '0;
    ps_param_at = '0;
    ps_value_at = '0;
    ps_target   = TGT_NONE;
    ps_found    = '0;
  endtask

  task automatic store_value(pos_t p);
    case (ps_target)
      TGT_TO: begin
        ps_found.to_tag_start = ps_value_at;
        ps_found.to_tag_len   = p - ps_value_at;
      end
      TGT_FROM: begin
        ps_found.from_tag_start = ps_value_at;
        ps_found.from_tag_len   = p - ps_value_at;
      end
      TGT_EARLY: begin
        ps_found.early_start       = ps_param_at;
        ps_found.early_len         = p - ps_param_at;
        ps_found.early_value_start = ps_value_at;
        ps_found.early_value_len   = p - ps_value_at;
      end
      default: ;
    endcase
  endtask

  task automatic store_early_name(pos_t p);
    ps_found.early_start = ps_param_at;
    ps_found.early_len   = p - ps_param_at;
  endtask

  // advance the model by one accepted byte; a last byte yields one expected result
  task automatic parse_byte(srhp_in_t it);
    logic [7:0] c;
    logic [7:0] lc;
    pos_t       p;
    state_t     s;
    c  = it.body_byte;
    lc = (c >= CH_UC_A && c <= CH_UC_Z) ? c + CH_CASE : c;
    s  = ps_state;
    // offsets stick at MAX_LEN once the body runs long
    if (ps_pos >= MAX_POS) begin
      p = MAX_POS;
      ps_found.too_long = 1'b1;
    end else begin
      p = ps_pos;
      ps_pos = ps_pos + 1'b1;
    end
    case (s)
      ST_CALLID: begin
        if (c == CH_SEMI) begin
          ps_found.callid_len = p;
          s = ST_PARAM;
        end
      end
      ST_PARAM: begin
        // a byte that starts no known name is simply skipped
        if (c != CH_SEMI) begin
          ps_param_at = p;
          if (lc == CH_T) s = ST_T1;
          else if (lc == CH_F) s = ST_F1;
          else if (lc == CH_E) s = ST_E1;
        end
      end
      ST_SKIP: begin
        if (c == CH_SEMI) s = ST_PARAM;
        else if (c == CH_EQ) s = ST_SKIPVAL;
      end
      ST_SKIPVAL: begin
        if (c == CH_SEMI) s = ST_PARAM;
      end
      ST_VALUE: begin
        if (c == CH_SEMI) begin
          store_value(p);
          s = ST_PARAM;
        end
      end
      ST_TO_EQ, ST_FROM_EQ, ST_EARLY_EQ: begin
        ps_target = (s == ST_TO_EQ) ? TGT_TO : (s == ST_FROM_EQ) ? TGT_FROM : TGT_EARLY;
        // empty value records nothing
        if (c == CH_SEMI) begin
          s = ST_PARAM;
        end else begin
          ps_value_at = p;
          s = ST_VALUE;
        end
      end
      ST_EARLY_FIN: begin
        if (c == CH_EQ) begin
          s = ST_EARLY_EQ;
        end else if (c == CH_SEMI) begin
          store_early_name(p);
          s = ST_PARAM;
        end else begin
          s = ST_SKIP;
        end
      end
      default: begin
        if (lc == name_char(s)) s = state_t'(s + 1);
        else if (c == CH_SEMI) s = ST_PARAM;
        else s = ST_SKIP;
      end
    endcase
    ps_state = s;
    if (it.last) begin
      // close whatever is still open at the end of the body
      if (s == ST_CALLID) ps_found.callid_len = ps_pos;
      else if (s == ST_EARLY_FIN || s == ST_EARLY_EQ) store_early_name(ps_pos);
      else if (s == ST_VALUE) store_value(ps_pos);
      span_q.push_back(ps_found);
      if (ps_found.too_long) long_bodies++;
      parse_reset();
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= ERR_PRINTS)
      $display("mismatch on %s: got %0d expected %0d (result %0d, cycle %0d)",
               what, got, want, results_checked, cycles);
  endtask

  task automatic check_result(srhp_out_t got);
    srhp_out_t want;
    if (span_q.size() == 0) begin
      report_mismatch("result with none expected, callid_len", int'(got.callid_len), 0);
      return;
    end
    want = span_q.pop_front();
    results_checked++;
    if (got.callid_len !== want.callid_len)
      report_mismatch("callid_len", int'(got.callid_len), int'(want.callid_len));
    if (got.to_tag_start !== want.to_tag_start)
      report_mismatch("to_tag_start", int'(got.to_tag_start), int'(want.to_tag_start));
    if (got.to_tag_len !== want.to_tag_len)
      report_mismatch("to_tag_len", int'(got.to_tag_len), int'(want.to_tag_len));
    if (got.from_tag_start !== want.from_tag_start)
      report_mismatch("from_tag_start", int'(got.from_tag_start), int'(want.from_tag_start));
    if (got.from_tag_len !== want.from_tag_len)
      report_mismatch("from_tag_len", int'(got.from_tag_len), int'(want.from_tag_len));
    if (got.early_start !== want.early_start)
      report_mismatch("early_start", int'(got.early_start), int'(want.early_start));
    if (got.early_len !== want.early_len)
      report_mismatch("early_len", int'(got.early_len), int'(want.early_len));
    if (got.early_value_start !== want.early_value_start)
      report_mismatch("early_value_start", int'(got.early_value_start),
                      int'(want.early_value_start));
    if (got.early_value_len !== want.early_value_len)
      report_mismatch("early_value_len", int'(got.early_value_len),
                      int'(want.early_value_len));
    if (got.too_long !== want.too_long)
      report_mismatch("too_long", int'(got.too_long), int'(want.too_long));
  endtask

  // sample both channels at the rising edge; the model only sees accepted bytes
  always @(posedge clk) begin
    in_fired = 1'b0;
    cycles++;
    if (!rst) begin
      if (in_valid && in_ready) begin
        in_fired = 1'b1;
        bytes_sent++;
        parse_byte(in_item);
      end
      if (in_valid && !in_ready) in_stalls++;
      if (out_valid && out_ready) check_result(out_item);
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles, span_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driving

  // sender: next byte goes out at the falling edge, with random gaps while idling is on
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (send_gap == 0 && idle_on && $urandom_range(0, 15) == 0)
        send_gap = $urandom_range(1, 12);
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (body_bytes_q.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        in_item  <= body_bytes_q.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end else if (hold_left == 0 && idle_on && $urandom_range(0, 15) == 0) begin
        hold_left = $urandom_range(1, 12);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- body generation

  function automatic logic [7:0] any_but_semi();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_SEMI);
    return c;
  endfunction

  // append text, optionally flipping letters to upper case at random
  task automatic put_text(string t, bit mix);
    logic [7:0] ch;
    for (int i = 0; i < t.len(); i++) begin
      ch = t[i];
      if (mix && ch >= CH_UC_A + CH_CASE && ch <= CH_UC_Z + CH_CASE && $urandom_range(0, 1))
        ch = ch - CH_CASE;
      body_buf.push_back(ch);
    end
  endtask

  task automatic put_value(int n);
    repeat (n) body_buf.push_back(any_but_semi());
  endtask

  task automatic put_param(int kind);
    string nm;
    int    cut;
    case (kind)
      K_TO: begin
        put_text(to_name, 1'b1);
        put_value($urandom_range(0, 4));
      end
      K_FROM: begin
        put_text(from_name, 1'b1);
        put_value($urandom_range(0, 4));
      end
      K_EARLY: put_text(early_name, 1'b1);
      K_EARLY_VAL: begin
        put_text(early_name, 1'b1);
        body_buf.push_back(CH_EQ);
        put_value($urandom_range(0, 3));
      end
      K_UNKNOWN: begin
        repeat ($urandom_range(1, 4)) body_buf.push_back(8'(CH_A + $urandom_range(0, 25)));
        if ($urandom_range(0, 1)) begin
          body_buf.push_back(CH_EQ);
          put_value($urandom_range(0, 3));
        end
      end
      K_BROKEN: begin
        // known name cut short and followed by a stray byte
        case ($urandom_range(0, 2))
          0: nm = to_name;
          1: nm = from_name;
          default: nm = early_name;
        endcase
        cut = $urandom_range(1, nm.len() - 1);
        put_text(nm.substr(0, cut - 1), 1'b1);
        body_buf.push_back(any_but_semi());
      end
      K_JUNK: begin
        // unknown leading characters ahead of a real name
        repeat ($urandom_range(1, 2)) body_buf.push_back(any_but_semi());
        put_param($urandom_range(K_TO, K_EARLY_VAL));
      end
      K_NOISE: repeat ($urandom_range(1, 3)) body_buf.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
  endtask

  // mostly well-formed bodies with random content, some pure noise
  task automatic build_body();
    int nparams;
    int kind;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 10)) body_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    put_value($urandom_range(0, 6));
    if ($urandom_range(0, 7) != 0) begin
      nparams = $urandom_range(1, 4);
      repeat (nparams) begin
        body_buf.push_back(CH_SEMI);
        kind = $urandom_range(0, 12);
        if (kind > K_EMPTY) kind = kind - 9;
        put_param(kind);
      end
      if ($urandom_range(0, 5) == 0) body_buf.push_back(CH_SEMI);
    end
  endtask

  // hand the built body to the sender, marking its final byte
  task automatic queue_body();
    srhp_in_t it;
    while (body_bytes_q.size() > QUEUE_AHEAD) @(posedge clk);
    if (body_buf.size() == 0) body_buf.push_back(any_but_semi());
    while (body_buf.size() != 0) begin
      it.body_byte = body_buf.pop_front();
      it.last      = (body_buf.size() == 0);
      body_bytes_q.push_back(it);
      bytes_queued++;
    end
    bodies_queued++;
  endtask

  task automatic drain();
    while (body_bytes_q.size() != 0 || in_valid || span_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    bit long_done;
    long_done = 1'b0;
    parse_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extreme byte values, call-id closed by a trailing semicolon
    body_buf.push_back(8'h00);
    body_buf.push_back(8'hff);
    body_buf.push_back(CH_SEMI);
    queue_body();
    // skipped leading character, to-tag, upper-case early-only closing the body
    put_text(";Xto-tag=1;EARLY-ONLY", 1'b0);
    queue_body();

    // sender pauses until every result is back
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    // receiver holds off while the sender keeps offering, so the input backs up
    hold_req = 1'b1;
    repeat (12) begin
      build_body();
      queue_body();
    end

    while (bytes_queued < BODY_BYTES) begin
      if (!long_done && bytes_queued > 700) begin
        // one body past MAX_LEN: to-tag value straddles the limit
        put_value(1000);
        body_buf.push_back(CH_SEMI);
        put_text(to_name, 1'b1);
        put_value(40);
        body_buf.push_back(CH_SEMI);
        put_text(early_name, 1'b1);
        long_done = 1'b1;
      end else begin
        build_body();
      end
      if (bytes_queued > BODY_BYTES - 250) idle_on = 1'b0;
      else if ($urandom_range(0, 19) == 0) idle_on = !idle_on;
      queue_body();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (span_q.size() != 0) report_mismatch("results never delivered", 0, span_q.size());

    $display("run covered %0d bodies in %0d bytes, %0d results checked, %0d over MAX_LEN",
             bodies_queued, bytes_sent, results_checked, long_bodies);
    $display("input was held back for %0d cycles by output back-pressure", in_stalls);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/srhp_pkg.sv
src/srhp_front.sv
src/srhp_queue.sv
src/srhp_back.sv
src/sip_replaces_header_parser_core.sv
verif/tb.sv
